// ----- hw/rtl/wavp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavp_pkg: shared types and constants of the WAV PCM parser
// Result item layout, parser phases, header tags, positions and codes.
// ----------------------------------------------------------------------------
package wavp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_HALT
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [3:0] ERR_RIFF      = 4'd0;
  localparam logic [3:0] ERR_WAVE      = 4'd1;
  localparam logic [3:0] ERR_FMT_ID    = 4'd2;
  localparam logic [3:0] ERR_FMT_SIZE  = 4'd3;
  localparam logic [3:0] ERR_FORMAT    = 4'd4;
  localparam logic [3:0] ERR_CHANNELS  = 4'd5;
  localparam logic [3:0] ERR_BYTE_RATE = 4'd6;
  localparam logic [3:0] ERR_ALIGN     = 4'd7;
  localparam logic [3:0] ERR_DATA_ID   = 4'd8;
  localparam logic [3:0] ERR_WIDTH     = 4'd9;

  // Header byte positions at which a field completes
  localparam logic [5:0] POS_RIFF      = 6'd3;
  localparam logic [5:0] POS_WAVE      = 6'd11;
  localparam logic [5:0] POS_FMT_ID    = 6'd15;
  localparam logic [5:0] POS_FMT_SIZE  = 6'd19;
  localparam logic [5:0] POS_FORMAT    = 6'd21;
  localparam logic [5:0] POS_CHANNELS  = 6'd23;
  localparam logic [5:0] POS_RATE      = 6'd27;
  localparam logic [5:0] POS_BYTE_RATE = 6'd31;
  localparam logic [5:0] POS_ALIGN     = 6'd33;
  localparam logic [5:0] POS_WIDTH     = 6'd35;
  localparam logic [5:0] POS_DATA_ID   = 6'd39;
  localparam logic [5:0] POS_DATA_SIZE = 6'd43;

  // Four-character tags as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE   = 32'd16;
  localparam logic [15:0] FORMAT_PCM = 16'd1;
  localparam logic [15:0] MONO       = 16'd1;
  localparam logic [15:0] WIDTH_8    = 16'd8;
  localparam logic [15:0] WIDTH_16   = 16'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    logic [31:0] hdr_rate;
    logic [15:0] hdr_width;
    logic [31:0] data_bytes;
    logic [3:0]  error_code;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/wavp_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavp_core: header checker and sample assembler
// Holds the parser state and forms at most one result per accepted byte.
// ----------------------------------------------------------------------------
module wavp_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic [7:0]       data_byte,
  input  wire logic             restart,
  output logic                  res_valid,
  output wavp_pkg::result_t     res
);

  wavp_pkg::phase_t phase_r, phase_nxt, ph_c;
  logic [5:0]  pos_r, pos_nxt, pos_c;
  logic [31:0] acc_r, acc_nxt, acc_c;
  logic [31:0] rate_r, rate_nxt, rate_c;
  logic [31:0] brate_r, brate_nxt, brate_c;
  logic [15:0] align_r, align_nxt, align_c;
  logic [15:0] width_r, width_nxt, width_c;
  logic [31:0] remain_r, remain_nxt, remain_c;
  logic [7:0]  partial_r, partial_nxt, partial_c;
  logic        bis_r, bis_nxt, bis_c;

  logic [31:0] acc_n;
  logic [15:0] hi;
  logic [47:0] prod;
  logic [31:0] rem_dec;
  logic        err_hit;
  logic [3:0]  err_code;

  // Restart makes this byte header byte zero: use reset values as current state
  assign ph_c      = restart ? wavp_pkg::PH_HEADER : phase_r;
  assign pos_c     = restart ? 6'd0  : pos_r;
  assign acc_c     = restart ? 32'd0 : acc_r;
  assign rate_c    = restart ? 32'd0 : rate_r;
  assign brate_c   = restart ? 32'd0 : brate_r;
  assign align_c   = restart ? 16'd0 : align_r;
  assign width_c   = restart ? 16'd0 : width_r;
  assign remain_c  = restart ? 32'd0 : remain_r;
  assign partial_c = restart ? 8'd0  : partial_r;
  assign bis_c     = restart ? 1'b0  : bis_r;

  assign acc_n   = {data_byte, acc_c[31:8]};
  assign hi      = acc_n[31:16];
  assign prod    = 48'(rate_c) * 48'(hi);
  assign rem_dec = remain_c - 32'd1;

  always_comb begin
    err_hit  = 1'b0;
    err_code = wavp_pkg::ERR_RIFF;
    case (pos_c)
      wavp_pkg::POS_RIFF: begin
        err_hit  = (acc_n != wavp_pkg::TAG_RIFF);
        err_code = wavp_pkg::ERR_RIFF;
      end
      wavp_pkg::POS_WAVE: begin
        err_hit  = (acc_n != wavp_pkg::TAG_WAVE);
        err_code = wavp_pkg::ERR_WAVE;
      end
      wavp_pkg::POS_FMT_ID: begin
        err_hit  = (acc_n != wavp_pkg::TAG_FMT);
        err_code = wavp_pkg::ERR_FMT_ID;
      end
      wavp_pkg::POS_FMT_SIZE: begin
        err_hit  = (acc_n != wavp_pkg::FMT_SIZE);
        err_code = wavp_pkg::ERR_FMT_SIZE;
      end
      wavp_pkg::POS_FORMAT: begin
        err_hit  = (hi != wavp_pkg::FORMAT_PCM);
        err_code = wavp_pkg::ERR_FORMAT;
      end
      wavp_pkg::POS_CHANNELS: begin
        err_hit  = (hi != wavp_pkg::MONO);
        err_code = wavp_pkg::ERR_CHANNELS;
      end
      wavp_pkg::POS_WIDTH: begin
        // rate first, then align, then width
        if (brate_c != {3'b000, prod[31:3]}) begin
          err_hit  = 1'b1;
          err_code = wavp_pkg::ERR_BYTE_RATE;
        end else if (align_c != {3'b000, hi[15:3]}) begin
          err_hit  = 1'b1;
          err_code = wavp_pkg::ERR_ALIGN;
        end else if (hi != wavp_pkg::WIDTH_8 && hi != wavp_pkg::WIDTH_16) begin
          err_hit  = 1'b1;
          err_code = wavp_pkg::ERR_WIDTH;
        end
      end
      wavp_pkg::POS_DATA_ID: begin
        err_hit  = (acc_n != wavp_pkg::TAG_DATA);
        err_code = wavp_pkg::ERR_DATA_ID;
      end
      default: begin
        err_hit  = 1'b0;
        err_code = wavp_pkg::ERR_RIFF;
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    rate_nxt    = rate_r;
    brate_nxt   = brate_r;
    align_nxt   = align_r;
    width_nxt   = width_r;
    remain_nxt  = remain_r;
    partial_nxt = partial_r;
    bis_nxt     = bis_r;
    if (in_fire) begin
      phase_nxt   = ph_c;
      pos_nxt     = pos_c;
      acc_nxt     = acc_c;
      rate_nxt    = rate_c;
      brate_nxt   = brate_c;
      align_nxt   = align_c;
      width_nxt   = width_c;
      remain_nxt  = remain_c;
      partial_nxt = partial_c;
      bis_nxt     = bis_c;
      case (ph_c)
        wavp_pkg::PH_HEADER: begin
          acc_nxt = acc_n;
          pos_nxt = 6'(pos_c + 6'd1);
          case (pos_c)
            wavp_pkg::POS_RATE:      rate_nxt  = acc_n;
            wavp_pkg::POS_BYTE_RATE: brate_nxt = acc_n;
            wavp_pkg::POS_ALIGN:     align_nxt = hi;
            wavp_pkg::POS_WIDTH:     width_nxt = hi;
            wavp_pkg::POS_DATA_SIZE: begin
              remain_nxt = acc_n;
              bis_nxt    = 1'b0;
              phase_nxt  = (acc_n == 32'd0) ? wavp_pkg::PH_HALT : wavp_pkg::PH_DATA;
            end
            default: ;
          endcase
          if (err_hit) begin
            phase_nxt = wavp_pkg::PH_HALT;
          end
        end
        wavp_pkg::PH_DATA: begin
          remain_nxt = rem_dec;
          if (width_c == wavp_pkg::WIDTH_8) begin
            if (rem_dec == 32'd0) begin
              phase_nxt = wavp_pkg::PH_HALT;
            end
          end else if (!bis_c) begin
            partial_nxt = data_byte;
            bis_nxt     = 1'b1;
            // a lone trailing byte ends the stream with no sample
            if (rem_dec == 32'd0) begin
              phase_nxt = wavp_pkg::PH_HALT;
            end
          end else begin
            bis_nxt = 1'b0;
            if (rem_dec < 32'd2) begin
              phase_nxt = wavp_pkg::PH_HALT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (ph_c)
      wavp_pkg::PH_HEADER: begin
        if (err_hit) begin
          res_valid      = in_fire;
          res.kind       = wavp_pkg::KIND_ERROR;
          res.error_code = err_code;
        end else if (pos_c == wavp_pkg::POS_DATA_SIZE) begin
          res_valid      = in_fire;
          res.kind       = wavp_pkg::KIND_HEADER;
          res.hdr_rate   = rate_c;
          res.hdr_width  = width_c;
          res.data_bytes = acc_n;
          res.last       = (acc_n == 32'd0);
        end
      end
      wavp_pkg::PH_DATA: begin
        if (width_c == wavp_pkg::WIDTH_8) begin
          res_valid  = in_fire;
          res.kind   = wavp_pkg::KIND_SAMPLE;
          res.sample = {{8{data_byte[7]}}, data_byte};
          res.last   = (rem_dec == 32'd0);
        end else if (bis_c) begin
          res_valid  = in_fire;
          res.kind   = wavp_pkg::KIND_SAMPLE;
          res.sample = {data_byte, partial_c};
          res.last   = (rem_dec < 32'd2);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wavp_pkg::PH_HEADER;
      pos_r     <= 6'd0;
      acc_r     <= 32'd0;
      rate_r    <= 32'd0;
      brate_r   <= 32'd0;
      align_r   <= 16'd0;
      width_r   <= 16'd0;
      remain_r  <= 32'd0;
      partial_r <= 8'd0;
      bis_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      acc_r     <= acc_nxt;
      rate_r    <= rate_nxt;
      brate_r   <= brate_nxt;
      align_r   <= align_nxt;
      width_r   <= width_nxt;
      remain_r  <= remain_nxt;
      partial_r <= partial_nxt;
      bis_r     <= bis_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/wavp_obuf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavp_obuf: result register with skid stage
// Decouples the output handshake from byte acceptance.
// ----------------------------------------------------------------------------
module wavp_obuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire wavp_pkg::result_t push_data,
  output logic                   can_accept,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output wavp_pkg::result_t      out_data
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  wavp_pkg::result_t out_data_r, out_data_nxt;
  wavp_pkg::result_t skid_data_r, skid_data_nxt;
  logic              pop;

  assign pop        = out_valid_r & out_ready;
  assign can_accept = ~skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        // drain the skid stage; no push can arrive while it is full
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/wav_pcm_header_and_sample_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A result item is registered in the output register, or held in the skid stage first, before it appears on out_tvalid.
// Throughput: one byte item per cycle while in_tready is high; in_tready drops while the skid stage is full.
// The two-deep result buffer keeps in_tready high while one result waits downstream.
// Reset: synchronous active-low rst_n returns the parser to header byte zero
// and empties the result buffer; in_tuser high makes its accepted byte header byte zero, for the parser alone.
// ----------------------------------------------------------------------------
// wav_pcm_header_and_sample_parser: streaming WAV PCM mono parser
// Checks the canonical 44-byte header, reports it, then emits 8 or 16 bit samples.
// ----------------------------------------------------------------------------
module wav_pcm_header_and_sample_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input byte channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tuser,   // [0] restart
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // [15:0] sample, [47:16] hdr_rate,
                                        // [63:48] hdr_width, [95:64] data_bytes,
                                        // [99:96] error_code, [103:100] zero
  output logic [1:0]        out_tuser,  // [1:0] kind
  output logic              out_tlast   // last
);

  logic              in_fire;
  logic              res_valid;
  wavp_pkg::result_t res;
  wavp_pkg::result_t out_res;

  // Accept a byte whenever the skid stage has room for its possible result
  assign in_fire = in_tvalid & in_tready;

  wavp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_tdata),
    .restart   (in_tuser),
    .res_valid (res_valid),
    .res       (res)
  );

  wavp_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  // Pack payload fields from the lowest bit up, padded to whole bytes
  assign out_tdata = {4'b0000, out_res.error_code, out_res.data_bytes,
                      out_res.hdr_width, out_res.hdr_rate, out_res.sample};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the WAV PCM header and sample parser
// Streams whole WAV files, faulty headers, truncated files and noise into the
// byte channel. A software model of the parser predicts every result item,
// and each accepted result is compared field by field with the oldest
// prediction. Both channels idle at random; the receiver also holds off for
// long stretches and the sender sometimes drains before the next file.
// ----------------------------------------------------------------------------
module tb_top;
  import wavp_pkg::*;

  localparam int NO_FAULT   = -1;
  localparam int FULL_HDR   = 44;
  localparam int RAND_ITEMS = 300;
  localparam int HOLD_LEN   = 400;

  // One byte item waiting to be offered. drain_first holds the sender until
  // every predicted result has arrived.
  typedef struct {
    logic [7:0] data_b;
    logic       restart;
    bit         drain_first;
  } wav_byte_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'd0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  wav_byte_t byte_stream_q[$];   // file bytes not yet offered
  result_t   parse_results_q[$]; // results predicted but not yet seen

  int n_fail = 0;
  int n_accepted = 0;
  int stream_len = 0;
  int directed_len = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit hold_off = 1'b0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  // Software copy of the parser state
  phase_t      phase_q;
  logic [5:0]  hdr_pos;
  logic [31:0] field_acc;
  logic [31:0] rate_st;
  logic [31:0] brate_st;
  logic [15:0] align_st;
  logic [15:0] width_st;
  logic [31:0] remain;
  logic [7:0]  low_byte;
  logic        half;

  wav_pcm_header_and_sample_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  function automatic void clear_parser();
    phase_q   = PH_HEADER;
    hdr_pos   = '0;
    field_acc = '0;
    rate_st   = '0;
    brate_st  = '0;
    align_st  = '0;
    width_st  = '0;
    remain    = '0;
    low_byte  = '0;
    half      = 1'b0;
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic restart,
                                    output result_t r);
    logic [31:0] acc;
    logic [15:0] hi;
    logic [5:0]  pos;
    logic [31:0] prod;
    bit          bad;
    logic [3:0]  code;
    r = '0;
    bad = 1'b0;
    code = '0;
    if (restart) clear_parser();
    case (phase_q)
      PH_HEADER: begin
        pos = hdr_pos;
        acc = {b, field_acc[31:8]};
        hi = acc[31:16];
        field_acc = acc;
        hdr_pos = pos + 6'd1;
        case (pos)
          POS_RIFF:      if (acc != TAG_RIFF) begin bad = 1'b1; code = ERR_RIFF; end
          POS_WAVE:      if (acc != TAG_WAVE) begin bad = 1'b1; code = ERR_WAVE; end
          POS_FMT_ID:    if (acc != TAG_FMT) begin bad = 1'b1; code = ERR_FMT_ID; end
          POS_FMT_SIZE:  if (acc != FMT_SIZE) begin bad = 1'b1; code = ERR_FMT_SIZE; end
          POS_FORMAT:    if (hi != FORMAT_PCM) begin bad = 1'b1; code = ERR_FORMAT; end
          POS_CHANNELS:  if (hi != MONO) begin bad = 1'b1; code = ERR_CHANNELS; end
          POS_RATE:      rate_st = acc;
          POS_BYTE_RATE: brate_st = acc;
          POS_ALIGN:     align_st = hi;
          POS_WIDTH: begin
            // byte rate first, then block align, then the width itself
            width_st = hi;
            prod = rate_st * {16'd0, width_st};
            if (brate_st != (prod >> 3)) begin
              bad = 1'b1;
              code = ERR_BYTE_RATE;
            end else if (align_st != (width_st >> 3)) begin
              bad = 1'b1;
              code = ERR_ALIGN;
            end else if (width_st != WIDTH_8 && width_st != WIDTH_16) begin
              bad = 1'b1;
              code = ERR_WIDTH;
            end
          end
          POS_DATA_ID:   if (acc != TAG_DATA) begin bad = 1'b1; code = ERR_DATA_ID; end
          POS_DATA_SIZE: begin
            remain = acc;
            half = 1'b0;
            r.kind = KIND_HEADER;
            r.hdr_rate = rate_st;
            r.hdr_width = width_st;
            r.data_bytes = acc;
            r.last = (acc == 32'd0);
            phase_q = (acc == 32'd0) ? PH_HALT : PH_DATA;
            return 1'b1;
          end
          default: ;
        endcase
        if (bad) begin
          r.kind = KIND_ERROR;
          r.error_code = code;
          phase_q = PH_HALT;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_DATA: begin
        remain = remain - 32'd1;
        if (width_st == WIDTH_8) begin
          r.sample = {{8{b[7]}}, b};
          r.last = (remain == 32'd0);
        end else if (!half) begin
          // low byte of a 16-bit sample; a lone trailing byte ends the file
          low_byte = b;
          half = 1'b1;
          if (remain == 32'd0) phase_q = PH_HALT;
          return 1'b0;
        end else begin
          half = 1'b0;
          r.sample = {b, low_byte};
          r.last = (remain < 32'd2);
        end
        r.kind = KIND_SAMPLE;
        if (r.last) phase_q = PH_HALT;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Mostly short gaps, a few long ones; none while in a calm stretch.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_b(input logic [7:0] b, input logic rs, input bit drain);
    wav_byte_t it;
    it.data_b = b;
    it.restart = rs;
    it.drain_first = drain;
    byte_stream_q.push_back(it);
    stream_len++;
  endtask

  task automatic push_data(input int count);
    for (int i = 0; i < count; i++) push_b(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  // Queue a canonical header, optionally cut short or with one field broken.
  task automatic push_header(input logic [31:0] rate, input logic [15:0] width,
                             input logic [31:0] n, input int fault,
                             input int hdr_len, input bit drain);
    logic [31:0] words [11];
    words[0]  = TAG_RIFF;
    words[1]  = $urandom;
    words[2]  = TAG_WAVE;
    words[3]  = TAG_FMT;
    words[4]  = FMT_SIZE;
    words[5]  = {MONO, FORMAT_PCM};
    words[6]  = rate;
    words[7]  = (rate * {16'd0, width}) >> 3;
    words[8]  = {width, width >> 3};
    words[9]  = TAG_DATA;
    words[10] = n;
    // flip one bit of the field under test; a width fault comes in via width
    case (fault)
      ERR_RIFF:      words[0] ^= 32'd1 << $urandom_range(31);
      ERR_WAVE:      words[2] ^= 32'd1 << $urandom_range(31);
      ERR_FMT_ID:    words[3] ^= 32'd1 << $urandom_range(31);
      ERR_FMT_SIZE:  words[4] ^= 32'd1 << $urandom_range(31);
      ERR_FORMAT:    words[5] ^= 32'd1 << $urandom_range(15);
      ERR_CHANNELS:  words[5] ^= 32'd1 << $urandom_range(16, 31);
      ERR_BYTE_RATE: words[7] ^= 32'd1 << $urandom_range(31);
      ERR_ALIGN:     words[8] ^= 32'd1 << $urandom_range(15);
      ERR_DATA_ID:   words[9] ^= 32'd1 << $urandom_range(31);
      default: ;
    endcase
    for (int k = 0; k < hdr_len; k++)
      push_b(words[k / 4][8 * (k % 4) +: 8], k == 0, drain && k == 0);
  endtask

  function automatic logic [15:0] bad_width();
    logic [15:0] w;
    do w = 16'($urandom_range(65535)); while (w == WIDTH_8 || w == WIDTH_16);
    return w;
  endfunction

  task automatic build_stream();
    logic [7:0]  extremes8 [6]  = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'hFE};
    logic [7:0]  extremes16 [5] = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h55};
    logic [31:0] rate;
    logic [31:0] n;
    logic [15:0] width;
    int          r;
    int          fault;
    int          send;
    int          start_len;

    // 8-bit file through the sign extremes, then bytes past the end
    push_header(32'd8000, WIDTH_8, 32'd6, NO_FAULT, FULL_HDR, 1'b0);
    foreach (extremes8[i]) push_b(extremes8[i], 1'b0, 1'b0);
    push_data(2);
    // 16-bit file with an odd count: lone trailing byte gives no sample
    push_header(32'd44100, WIDTH_16, 32'd5, NO_FAULT, FULL_HDR, 1'b0);
    foreach (extremes16[i]) push_b(extremes16[i], 1'b0, 1'b0);
    push_data(1);
    // empty data chunk: header alone carries last
    push_header(32'd22050, WIDTH_16, 32'd0, NO_FAULT, FULL_HDR, 1'b0);
    push_data(2);
    // byte rate product wraps modulo 2^32; wait for the pipe to drain first
    push_header(32'hFFFF_FFFF, WIDTH_16, 32'd2, NO_FAULT, FULL_HDR, 1'b1);
    push_b(8'hFF, 1'b0, 1'b0);
    push_b(8'hFF, 1'b0, 1'b0);
    // huge count, rate zero: data cut off by the next restart
    push_header(32'd0, WIDTH_8, 32'hFFFF_FFFF, NO_FAULT, FULL_HDR, 1'b0);
    push_data(4);
    // each header check failing in turn, the rest of the file ignored
    for (int f = ERR_RIFF; f <= ERR_DATA_ID; f++) begin
      if (f == ERR_WIDTH) continue;
      push_header(32'd48000, WIDTH_16, 32'd4, f, FULL_HDR, 1'b0);
      push_data(2);
    end
    push_header(32'd16000, 16'd0, 32'd4, ERR_WIDTH, FULL_HDR, 1'b0);
    push_header(32'd16000, 16'hFFFF, 32'd4, ERR_WIDTH, FULL_HDR, 1'b0);
    push_header(32'd96000, 16'd24, 32'd4, ERR_WIDTH, FULL_HDR, 1'b0);
    push_data(2);
    // restart in the middle of a header
    push_header(32'd11025, WIDTH_8, 32'd3, NO_FAULT, 20, 1'b0);
    push_header(32'd11025, WIDTH_8, 32'd3, NO_FAULT, FULL_HDR, 1'b0);
    push_data(3);
    directed_len = stream_len;

    // random files: mostly well formed, some faulty, cut short, or noise
    start_len = stream_len;
    while (stream_len - start_len < RAND_ITEMS) begin
      r = $urandom_range(99);
      rate = $urandom_range(1) ? $urandom : 32'($urandom_range(8000, 96000));
      if (r < 5) begin
        push_b(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
        push_data($urandom_range(0, 11));
      end else if (r < 18) begin
        fault = $urandom_range(ERR_RIFF, ERR_WIDTH);
        width = (fault == ERR_WIDTH) ? bad_width() :
                ($urandom_range(1) ? WIDTH_16 : WIDTH_8);
        push_header(rate, width, 32'($urandom_range(0, 8)), fault, FULL_HDR,
                    $urandom_range(99) < 3);
        push_data($urandom_range(0, 3));
      end else begin
        width = $urandom_range(1) ? WIDTH_16 : WIDTH_8;
        n = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 40));
        if ($urandom_range(99) < 4) begin
          push_header(rate, width, n, NO_FAULT, $urandom_range(1, FULL_HDR - 1), 1'b0);
          continue;
        end
        push_header(rate, width, n, NO_FAULT, FULL_HDR, $urandom_range(99) < 3);
        if (n > 32'd40) send = $urandom_range(0, 30);
        else if ($urandom_range(4) == 0) send = $urandom_range(0, int'(n));
        else send = int'(n) + $urandom_range(0, 3);
        push_data(send);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // Predict on every accepted byte; check every accepted result.
  always @(posedge clk) begin
    result_t want;
    bit      yields;
    in_taken <= rst_n && in_tvalid && in_tready;
    out_taken <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (parse_results_q.size() == 0) begin
        $error("result item with none expected: kind %0d", out_tuser);
        n_fail++;
      end else begin
        want = parse_results_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_tuser));
        check_field("sample", 32'(want.sample), 32'(out_tdata[15:0]));
        check_field("hdr_rate", want.hdr_rate, out_tdata[47:16]);
        check_field("hdr_width", 32'(want.hdr_width), 32'(out_tdata[63:48]));
        check_field("data_bytes", want.data_bytes, out_tdata[95:64]);
        check_field("error_code", 32'(want.error_code), 32'(out_tdata[99:96]));
        check_field("pad", 32'd0, 32'(out_tdata[103:100]));
        check_field("last", 32'(want.last), 32'(out_tlast));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      yields = parse_byte(in_tdata, in_tuser, want);
      if (yields) parse_results_q.push_back(want);
      n_accepted++;
    end
  end

  // Sender: hold the current item until taken, then idle or advance.
  always @(negedge clk) begin
    wav_byte_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (byte_stream_q.size() != 0 &&
                   !(byte_stream_q[0].drain_first && parse_results_q.size() != 0)) begin
        it = byte_stream_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= it.data_b;
        in_tuser <= it.restart;
        if ($urandom_range(99) == 0) calm_in = ~calm_in;
        in_gap = pick_gap(calm_in);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall after results and now and then while waiting.
  always @(negedge clk) begin
    if (out_gap == 0 && (out_taken || $urandom_range(99) < 3)) begin
      if ($urandom_range(99) == 0) calm_out = ~calm_out;
      out_gap = pick_gap(calm_out);
    end
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (out_gap != 0) begin
      out_tready <= 1'b0;
      out_gap--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Long receiver hold-offs while the sender keeps offering bytes.
  initial begin
    wait (directed_len != 0 && n_accepted >= directed_len + 50);
    hold_off = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off = 1'b0;
    wait (n_accepted >= directed_len + 200);
    hold_off = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    clear_parser();
    build_stream();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    wait (byte_stream_q.size() == 0 && !in_tvalid);
    wait (parse_results_q.size() == 0);
    // let any stray result surface before the verdict
    repeat (20) @(posedge clk);
    if (n_fail == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
